>>> hw/rtl/sfth_pkg.sv
// ----------------------------------------------------------------------------
// sfth_pkg
// Shared types and constants for the symmetric flow tuple hash unit.
// ----------------------------------------------------------------------------
package sfth_pkg;

  localparam int unsigned KEY_BYTES = 13;
  localparam int unsigned HASH_W    = 32;

  localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;
  localparam logic [HASH_W-1:0] FNV_BASIS  = 32'd2166136261;

  // byte 0 is hashed first
  typedef logic [KEY_BYTES-1:0][7:0] key_t;
  typedef logic [HASH_W-1:0]         hash_t;

endpackage

>>> hw/rtl/sfth_in_if.sv
// ----------------------------------------------------------------------------
// sfth_in_if
// Flow key channel: valid/ready handshake carrying one IPv4 five-tuple.
// ----------------------------------------------------------------------------
interface sfth_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_address;
  logic [31:0] target_address;
  logic [15:0] source_port;
  logic [15:0] target_port;
  logic [7:0]  protocol_number;

  modport source (
    output valid, source_address, target_address, source_port, target_port,
           protocol_number,
    input  ready
  );
  modport sink (
    input  valid, source_address, target_address, source_port, target_port,
           protocol_number,
    output ready
  );
endinterface

>>> hw/rtl/sfth_out_if.sv
// ----------------------------------------------------------------------------
// sfth_out_if
// Hash result channel: valid/ready handshake carrying one 32-bit flow hash.
// ----------------------------------------------------------------------------
interface sfth_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] flow_hash;

  modport source (
    output valid, flow_hash,
    input  ready
  );
  modport sink (
    input  valid, flow_hash,
    output ready
  );
endinterface

>>> hw/rtl/symmetric_flow_tuple_hash_unit.sv
// ----------------------------------------------------------------------------
// symmetric_flow_tuple_hash_unit
// FNV-1 32-bit hash of an IPv4 five-tuple with optional direction-insensitive
// endpoint ordering.
// ----------------------------------------------------------------------------
// The unit takes one flow key beat per clock while in_flow.ready is high and
// returns each hash, one result beat per clock when the output keeps up. The
// key is ordered on entry, then passes through a row of thirteen cells, one
// per key byte, each doing one 32-bit multiply by the FNV prime and a byte
// XOR; the last cell is the output register. A stall on the output fills
// empty cells first, so input beats are still taken until the row is full.
// keep_direction resets to 1 and must only be written while the unit is
// empty.
module symmetric_flow_tuple_hash_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_write_enable,
  input  logic cfg_write_data,
  sfth_in_if.sink    in_flow,
  sfth_out_if.source out_hash
);

  localparam int unsigned N = sfth_pkg::KEY_BYTES;

  logic            keep_direction_r;
  logic            keep_direction_nxt;
  sfth_pkg::key_t  entry_key;

  logic            stg_valid [N+1];
  logic            stg_ready [N+1];
  sfth_pkg::hash_t stg_hash  [N+1];
  sfth_pkg::key_t  stg_key   [N+1];

  always_comb begin
    keep_direction_nxt = cfg_write_enable ? cfg_write_data : keep_direction_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_direction_r <= 1'b1;
    end else begin
      keep_direction_r <= keep_direction_nxt;
    end
  end

  sfth_order u_order (
    .keep_direction  (keep_direction_r),
    .source_address  (in_flow.source_address),
    .target_address  (in_flow.target_address),
    .source_port     (in_flow.source_port),
    .target_port     (in_flow.target_port),
    .protocol_number (in_flow.protocol_number),
    .key             (entry_key)
  );

  assign stg_valid[0] = in_flow.valid;
  assign stg_hash[0]  = sfth_pkg::FNV_BASIS;
  assign stg_key[0]   = entry_key;
  assign in_flow.ready = stg_ready[0];

  for (genvar gi = 0; gi < N; gi++) begin : g_cell
    sfth_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[gi]),
      .up_ready (stg_ready[gi]),
      .up_hash  (stg_hash[gi]),
      .up_key   (stg_key[gi]),
      .dn_valid (stg_valid[gi+1]),
      .dn_ready (stg_ready[gi+1]),
      .dn_hash  (stg_hash[gi+1]),
      .dn_key   (stg_key[gi+1])
    );
  end

  assign out_hash.valid     = stg_valid[N];
  assign out_hash.flow_hash = stg_hash[N];
  assign stg_ready[N]       = out_hash.ready;

  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_write_enable |=> $stable(keep_direction_r))
    else $error("direction mode changed without a write");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_write_enable |=> keep_direction_r == $past(cfg_write_data))
    else $error("direction mode write lost");

  a_out_stall_blocks_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_flow.ready |-> out_hash.valid && !out_hash.ready)
    else $error("input refused while output drains");

endmodule

>>> hw/rtl/sfth_order.sv
// ----------------------------------------------------------------------------
// sfth_order
// Endpoint ordering: optionally swaps ports and addresses so both directions
// of a flow give the same key, then lays the key out as bytes in hash order.
// ----------------------------------------------------------------------------
module sfth_order (
  input  logic          keep_direction,
  input  logic [31:0]   source_address,
  input  logic [31:0]   target_address,
  input  logic [15:0]   source_port,
  input  logic [15:0]   target_port,
  input  logic [7:0]    protocol_number,
  output sfth_pkg::key_t key
);

  logic        swap_ports;
  logic        swap_addrs;
  logic [15:0] port_a;
  logic [15:0] port_b;
  logic [31:0] addr_a;
  logic [31:0] addr_b;

  always_comb begin
    swap_ports = !keep_direction && (target_port < source_port);
    swap_addrs = swap_ports ||
                 (!keep_direction && (target_port == source_port) &&
                  (target_address < source_address));
    port_a = swap_ports ? target_port : source_port;
    port_b = swap_ports ? source_port : target_port;
    addr_a = swap_addrs ? target_address : source_address;
    addr_b = swap_addrs ? source_address : target_address;

    // ports low byte first, addresses most significant byte first
    key[0]  = port_a[7:0];
    key[1]  = port_a[15:8];
    key[2]  = port_b[7:0];
    key[3]  = port_b[15:8];
    key[4]  = addr_a[31:24];
    key[5]  = addr_a[23:16];
    key[6]  = addr_a[15:8];
    key[7]  = addr_a[7:0];
    key[8]  = addr_b[31:24];
    key[9]  = addr_b[23:16];
    key[10] = addr_b[15:8];
    key[11] = addr_b[7:0];
    key[12] = protocol_number;
  end

endmodule

>>> hw/rtl/sfth_cell.sv
// ----------------------------------------------------------------------------
// sfth_cell
// One FNV-1 byte step: multiplies the running hash by the prime, XORs in the
// lowest key byte and hands hash and remaining key bytes to the next cell.
// ----------------------------------------------------------------------------
module sfth_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  sfth_pkg::hash_t up_hash,
  input  sfth_pkg::key_t  up_key,
  output logic           dn_valid,
  input  logic           dn_ready,
  output sfth_pkg::hash_t dn_hash,
  output sfth_pkg::key_t  dn_key
);

  logic            valid_r;
  logic            valid_nxt;
  sfth_pkg::hash_t hash_r;
  sfth_pkg::hash_t hash_nxt;
  sfth_pkg::key_t  key_r;
  sfth_pkg::key_t  key_nxt;

  always_comb begin
    up_ready  = !valid_r || dn_ready;
    valid_nxt = up_ready ? up_valid : valid_r;
    hash_nxt  = sfth_pkg::hash_t'(up_hash * sfth_pkg::HASH_PRIME) ^
                {{(sfth_pkg::HASH_W-8){1'b0}}, up_key[0]};
    // next byte moves into the low slot
    key_nxt   = sfth_pkg::key_t'(up_key >> 8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      hash_r <= hash_nxt;
      key_r  <= key_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_hash  = hash_r;
  assign dn_key   = key_r;

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !valid_r |-> up_ready)
    else $error("empty cell refused a beat");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !dn_ready |=> valid_r && $stable(hash_r))
    else $error("stalled cell lost or changed its beat");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    up_valid && up_ready |=> valid_r)
    else $error("accepted beat not held");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the symmetric flow tuple hash unit. Flow key beats
// are driven with bursty timing while the hash side stalls on its own
// pattern. Every accepted key is hashed by a local FNV-1 predictor under the
// current endpoint ordering mode, and each hash beat is compared in order.
// Directed corner keys run under both modes, followed by random phases that
// alternate the mode and favour equal ports and reversed flow pairs.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_PHASES  = 5;
  localparam int NUM_CORNERS = 11;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] target_address;
    logic [15:0] source_port;
    logic [15:0] target_port;
    logic [7:0]  protocol_number;
  } flow_key_t;

  class flow_hash_scoreboard_t;
    bit              keep_direction;
    sfth_pkg::hash_t expected_hashes[$];
    int              errors;

    function new();
      keep_direction = 1'b1;
      errors = 0;
    endfunction

    function sfth_pkg::hash_t flow_hash_of(flow_key_t k);
      logic [15:0]     port_a, port_b;
      logic [31:0]     addr_a, addr_b;
      logic            swap_ports, swap_addrs;
      sfth_pkg::key_t  key_bytes;
      sfth_pkg::hash_t h;
      swap_ports = 1'b0;
      swap_addrs = 1'b0;
      if (!keep_direction) begin
        swap_ports = k.target_port < k.source_port;
        swap_addrs = swap_ports || (k.source_port == k.target_port &&
                                    k.target_address < k.source_address);
      end
      port_a = swap_ports ? k.target_port : k.source_port;
      port_b = swap_ports ? k.source_port : k.target_port;
      addr_a = swap_addrs ? k.target_address : k.source_address;
      addr_b = swap_addrs ? k.source_address : k.target_address;
      key_bytes[0]  = port_a[7:0];
      key_bytes[1]  = port_a[15:8];
      key_bytes[2]  = port_b[7:0];
      key_bytes[3]  = port_b[15:8];
      for (int i = 0; i < 4; i++) begin
        key_bytes[4 + i] = addr_a[31 - 8*i -: 8];
        key_bytes[8 + i] = addr_b[31 - 8*i -: 8];
      end
      key_bytes[12] = k.protocol_number;
      h = sfth_pkg::FNV_BASIS;
      for (int i = 0; i < sfth_pkg::KEY_BYTES; i++) begin
        h = h * sfth_pkg::HASH_PRIME;
        h = h ^ {24'd0, key_bytes[i]};
      end
      return h;
    endfunction

    function void note_key(flow_key_t k);
      expected_hashes.push_back(flow_hash_of(k));
    endfunction

    function void check_hash(sfth_pkg::hash_t actual);
      sfth_pkg::hash_t expected;
      if (expected_hashes.size() == 0) begin
        $error("flow_hash beat with none expected: actual %h", actual);
        errors++;
      end else begin
        expected = expected_hashes.pop_front();
        if (actual !== expected) begin
          $error("flow_hash mismatch: expected %h, actual %h", expected, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_hashes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_write_enable;
  logic cfg_write_data;

  sfth_in_if  in_flow();
  sfth_out_if out_hash();

  flow_hash_scoreboard_t sb = new();

  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int hold_left  = 0;
  int cycle_count = 0;
  int idle_cycles = 0;

  symmetric_flow_tuple_hash_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_flow          (in_flow),
    .out_hash         (out_hash)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // beat monitor and mode tracking
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_flow.valid && in_flow.ready) begin
        sb.note_key('{in_flow.source_address, in_flow.target_address,
                      in_flow.source_port, in_flow.target_port,
                      in_flow.protocol_number});
      end
      if (out_hash.valid && out_hash.ready) begin
        sb.check_hash(out_hash.flow_hash);
      end
      if (cfg_write_enable) begin
        sb.keep_direction = cfg_write_data;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_write_enable || (in_flow.valid && in_flow.ready) ||
        (out_hash.valid && out_hash.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // hash side back-pressure
  always @(negedge clk) begin
    cycle_count++;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(32, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: begin
        out_hash.ready <= 1'b1;
      end
      1: begin
        out_hash.ready <= ($urandom_range(0, 9) < 7);
      end
      2: begin
        out_hash.ready <= (cycle_count % 4 == 0);
      end
      default: begin
        if (hold_left == 0) begin
          out_hash.ready <= ~out_hash.ready;
          hold_left = $urandom_range(1, 20);
        end else begin
          hold_left--;
        end
      end
    endcase
  end

  task automatic send_key(input flow_key_t k);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
      @(negedge clk) in_flow.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_flow.valid           <= 1'b1;
    in_flow.source_address  <= k.source_address;
    in_flow.target_address  <= k.target_address;
    in_flow.source_port     <= k.source_port;
    in_flow.target_port     <= k.target_port;
    in_flow.protocol_number <= k.protocol_number;
    do @(posedge clk); while (!in_flow.ready);
    burst_left--;
  endtask

  task automatic wait_drained();
    @(negedge clk) in_flow.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic set_keep_direction(input bit value);
    wait_drained();
    repeat (16) @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    @(negedge clk) cfg_write_enable <= 1'b0;
  endtask

  function automatic flow_key_t corner_key(int idx);
    case (idx)
      0:  return '{32'h0, 32'h0, 16'h0, 16'h0, 8'h00};
      1:  return '{32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 8'hff};
      2:  return '{32'hc0a80001, 32'h0a000001, 16'hffff, 16'h0000, 8'h06};
      3:  return '{32'h0a000001, 32'hc0a80001, 16'h0000, 16'hffff, 8'h06};
      4:  return '{32'hffffffff, 32'h00000000, 16'h1f90, 16'h1f90, 8'h11};
      5:  return '{32'h00000000, 32'hffffffff, 16'h1f90, 16'h1f90, 8'h11};
      6:  return '{32'h12345678, 32'h12345678, 16'h0035, 16'h0035, 8'h01};
      7:  return '{32'h80000000, 32'h7fffffff, 16'h0050, 16'hc350, 8'h00};
      8:  return '{32'h7fffffff, 32'h80000000, 16'hc350, 16'h0050, 8'hff};
      9:  return '{32'h01020304, 32'h01020304, 16'h8000, 16'h7fff, 8'h80};
      default: return '{32'haaaaaaaa, 32'h55555555, 16'h0001, 16'h0100, 8'h55};
    endcase
  endfunction

  task automatic send_random_flow(output int count);
    flow_key_t k;
    k = '{$urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom)};
    count = 1;
    case ($urandom_range(0, 9))
      4, 5: begin
        k.target_port = k.source_port;
      end
      6: begin
        k.target_port = k.source_port;
        k.target_address = k.source_address;
      end
      7: begin
        send_key(k);
        k = '{k.target_address, k.source_address, k.target_port,
              k.source_port, k.protocol_number};
        count = 2;
      end
      8: begin
        k.source_address  = $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
        k.target_address  = $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
        k.source_port     = $urandom_range(0, 1) ? 16'hffff : 16'h0;
        k.target_port     = $urandom_range(0, 1) ? 16'hffff : 16'h0;
        k.protocol_number = $urandom_range(0, 1) ? 8'hff : 8'h0;
      end
      9: begin
        k.target_port = k.source_port + ($urandom_range(0, 1) ? 16'd1 : -16'd1);
      end
      default: begin
      end
    endcase
    send_key(k);
  endtask

  initial begin
    int sent;
    int n;
    rst_n                   = 1'b0;
    cfg_write_enable        = 1'b0;
    cfg_write_data          = 1'b0;
    in_flow.valid           = 1'b0;
    in_flow.source_address  = '0;
    in_flow.target_address  = '0;
    in_flow.source_port     = '0;
    in_flow.target_port     = '0;
    in_flow.protocol_number = '0;
    out_hash.ready          = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // corner keys in given order, then endpoint ordered
    for (int i = 0; i < NUM_CORNERS; i++) send_key(corner_key(i));
    set_keep_direction(1'b0);
    for (int i = 0; i < NUM_CORNERS; i++) send_key(corner_key(i));

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_keep_direction(p[0]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random_flow(n);
        sent += n;
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

>>> files.f
hw/rtl/sfth_pkg.sv
hw/rtl/sfth_in_if.sv
hw/rtl/sfth_out_if.sv
hw/rtl/sfth_order.sv
hw/rtl/sfth_cell.sv
hw/rtl/symmetric_flow_tuple_hash_unit.sv
tb/sv/tb_top.sv
